// ----- hdl/rsg_pkg.sv -----
// types, constants and single-precision helpers for the sky gradient shader
// no dependencies; used by rsg_rsqrt and ray_sky_gradient_shader_unit
`default_nettype none
package rsg_pkg;

    typedef struct packed {
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
    localparam logic [31:0] F_HALF     = 32'h3f000000;
    localparam logic [31:0] F_ONE      = 32'h3f800000;
    localparam logic [31:0] F_ONE_P5   = 32'h3fc00000;
    localparam logic [31:0] F_128      = 32'h43000000;
    localparam logic [31:0] F_179      = 32'h43330000;
    localparam logic [31:0] F_255      = 32'h437f0000;
    localparam logic [31:0] F_QNAN     = 32'h7fc00000;
    localparam int RSQRT_LAT = 5;

    // leading zero count, word assumed non-zero
    function automatic logic [5:0] lzc48(input logic [47:0] p);
        logic [5:0] lz;
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (p[i]) begin
                lz = 6'(47 - i);
            end
        end
        return lz;
    endfunction

    // value = p * 2^(k - 173); normalise, round to nearest even, pack
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] k,
                                               input logic [47:0] p);
        logic [5:0]         lz;
        logic [47:0]        pn;
        logic signed [11:0] be;
        logic [6:0]         sh;
        logic [95:0]        wide;
        logic               st;
        logic               rnd;
        logic [30:0]        body;
        if (p == 48'd0) begin
            return {sgn, 31'd0};
        end
        lz = lzc48(p);
        pn = p << lz;
        be = k + 12'sd1 - $signed({6'd0, lz});
        st = 1'b0;
        if (be >= 12'sd255) begin
            return {sgn, 8'hff, 23'd0};
        end
        if (be < 12'sd1) begin
            sh   = (be < -12'sd60) ? 7'd61 : 7'(12'sd1 - be);
            wide = {pn, 48'd0} >> sh;
            pn   = wide[95:48];
            st   = |wide[47:0];
            be   = 12'sd0;
        end
        st   = st | (|pn[22:0]);
        rnd  = pn[23] & (st | pn[24]);
        body = {be[7:0], pn[46:24]} + 31'(rnd);
        return {sgn, body};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               sgn;
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic signed [11:0] k;
        sgn    = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            return F_QNAN;
        end
        if (a_inf || b_inf) begin
            return {sgn, 8'hff, 23'd0};
        end
        if (a_zero || b_zero) begin
            return {sgn, 31'd0};
        end
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        k  = $signed({4'd0, ((a[30:23] == 8'd0) ? 8'd1 : a[30:23])})
           + $signed({4'd0, ((b[30:23] == 8'd0) ? 8'd1 : b[30:23])}) - 12'sd127;
        return round_pack(sgn, k, ma * mb);
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [4:0]  dc;
        logic [26:0] mbig;
        logic [53:0] wide;
        logic [26:0] al;
        logic [27:0] r;
        logic        sgn;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            return F_QNAN;
        end
        if (a_inf) begin
            return a;
        end
        if (b_inf) begin
            return b;
        end
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb - es;
        dc   = (d > 8'd28) ? 5'd28 : d[4:0];
        mbig = {(big[30:23] != 8'd0), big[22:0], 3'd0};
        wide = {(sml[30:23] != 8'd0), sml[22:0], 3'd0, 27'd0} >> dc;
        al   = {wide[53:28], wide[27] | (|wide[26:0])};
        if (big[31] == sml[31]) begin
            r = {1'b0, mbig} + {1'b0, al};
        end else begin
            r = {1'b0, mbig} - {1'b0, al};
        end
        sgn = (r == 28'd0) ? (a[31] & b[31]) : big[31];
        return round_pack(sgn, $signed({4'd0, eb}), {r, 20'd0});
    endfunction

    // truncate toward zero, saturate to 0..255, not-a-number gives 0
    function automatic logic [7:0] to_channel(input logic [31:0] v);
        logic [23:0] m;
        if (v[31] || (v[30:0] == 31'd0) || ((v[30:23] == 8'hff) && (v[22:0] != 23'd0))) begin
            return 8'd0;
        end
        if (v[30:0] >= F_255[30:0]) begin
            return 8'd255;
        end
        if (v[30:23] < 8'd127) begin
            return 8'd0;
        end
        m = {1'b1, v[22:0]} >> (8'd150 - v[30:23]);
        return m[7:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rsg_rsqrt.sv -----
// five-stage fast inverse square root: magic seed and one newton step
// depends on rsg_pkg
`default_nettype none
module rsg_rsqrt
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_valid,
    input  wire logic [31:0] s,
    output logic             inv_valid,
    output logic [31:0]      inv
);
    import rsg_pkg::*;

    logic [4:0]  valid_reg;
    logic [31:0] half_reg;
    logic [31:0] y0_reg [4];
    logic [31:0] a1_reg;
    logic [31:0] a2_reg;
    logic [31:0] b_reg;
    logic [31:0] inv_reg;
    logic [31:0] y0_next;

    // seed: arithmetic shift keeps the sign bit
    assign y0_next = MAGIC_SEED - {s[31], s[31:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 5'd0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg  <= fmul(s, F_HALF);
        y0_reg[0] <= y0_next;
        a1_reg    <= fmul(half_reg, y0_reg[0]);
        y0_reg[1] <= y0_reg[0];
        a2_reg    <= fmul(a1_reg, y0_reg[1]);
        y0_reg[2] <= y0_reg[1];
        b_reg     <= fadd(F_ONE_P5, {~a2_reg[31], a2_reg[30:0]});
        y0_reg[3] <= y0_reg[2];
        inv_reg   <= fmul(y0_reg[3], b_reg);
    end

    assign inv_valid = valid_reg[4];
    assign inv       = inv_reg;
endmodule
`default_nettype wire

// ----- hdl/ray_sky_gradient_shader_unit.sv -----
// top level of the sky gradient shader: direction word in, colour word out
// depends on rsg_pkg and rsg_rsqrt
//
// channel   | handshake    | payload
// ----------+--------------+------------------------------------------
// direction | start / busy | dir   (dir_x, dir_y, dir_z float bits)
// colour    | done strobe  | color (red, green, blue, 8 bits each)
//
// one direction word is taken every cycle; busy is never raised
// one float multiply or add per register stage,
// the chain of dependent float operations sets the depth
// reset clears only the valid bits; payload registers are left alone
// the receiver cannot stall, so the pipeline never holds
`default_nettype none
module ray_sky_gradient_shader_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rsg_pkg::dir_t  dir,
    output logic                done,
    output rsg_pkg::color_t     color
);
    import rsg_pkg::*;

    // front: squares and squared length
    logic [2:0]  fv_reg;
    logic [31:0] xx_reg;
    logic [31:0] yy_reg;
    logic [31:0] zz_reg;
    logic [31:0] zz2_reg;
    logic [31:0] s1_reg;
    logic [31:0] s_reg;
    // y rides alongside until it meets the inverse length
    logic [31:0] y_reg [3 + RSQRT_LAT];

    logic        inv_valid;
    logic [31:0] inv;

    // back: normalised y, blend weights, products, sums, channels
    logic [6:0]  bv_reg;
    logic [31:0] ny_reg;
    logic [31:0] t1_reg;
    logic [31:0] t_reg;
    logic [31:0] t2_reg;
    logic [31:0] omt_reg;
    logic [31:0] pw_reg;
    logic [31:0] pr_reg;
    logic [31:0] pg_reg;
    logic [31:0] pb_reg;
    logic [31:0] sr_reg;
    logic [31:0] sg_reg;
    logic [31:0] sb_reg;
    color_t      color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 3'd0;
            bv_reg <= 7'd0;
        end
        else
        begin
            fv_reg <= {fv_reg[1:0], start};
            bv_reg <= {bv_reg[5:0], inv_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg   <= fmul(dir.dir_x, dir.dir_x);
        yy_reg   <= fmul(dir.dir_y, dir.dir_y);
        zz_reg   <= fmul(dir.dir_z, dir.dir_z);
        y_reg[0] <= dir.dir_y;
        s1_reg   <= fadd(xx_reg, yy_reg);
        zz2_reg  <= zz_reg;
        s_reg    <= fadd(s1_reg, zz2_reg);
        for (int i = 1; i < 3 + RSQRT_LAT; i++)
        begin
            y_reg[i] <= y_reg[i - 1];
        end
    end

    rsg_rsqrt u_rsqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (fv_reg[2]),
        .s         (s_reg),
        .inv_valid (inv_valid),
        .inv       (inv)
    );

    always_ff @(posedge clk)
    begin
        ny_reg    <= fmul(inv, y_reg[2 + RSQRT_LAT]);
        t1_reg    <= fadd(ny_reg, F_ONE);
        t_reg     <= fmul(F_HALF, t1_reg);
        // one minus t, t kept for the sky products
        omt_reg   <= fadd(F_ONE, {~t_reg[31], t_reg[30:0]});
        t2_reg    <= t_reg;
        // white term is the same for all three channels
        pw_reg    <= fmul(F_255, omt_reg);
        pr_reg    <= fmul(F_128, t2_reg);
        pg_reg    <= fmul(F_179, t2_reg);
        pb_reg    <= fmul(F_255, t2_reg);
        sr_reg    <= fadd(pw_reg, pr_reg);
        sg_reg    <= fadd(pw_reg, pg_reg);
        sb_reg    <= fadd(pw_reg, pb_reg);
        color_reg <= '{red: to_channel(sr_reg), green: to_channel(sg_reg),
                       blue: to_channel(sb_reg)};
    end

    assign busy  = 1'b0;
    assign done  = bv_reg[6];
    assign color = color_reg;
endmodule
`default_nettype wire
